>>> sv/cps_pkg.sv
// Shared types, constants and helpers for the cone point sampler.
package cps_pkg;

  // Register indexes
  localparam logic [2:0] REG_U_LOW       = 3'd0;
  localparam logic [2:0] REG_U_HIGH      = 3'd1;
  localparam logic [2:0] REG_RADIUS_LOW  = 3'd2;
  localparam logic [2:0] REG_RADIUS_HIGH = 3'd3;
  localparam logic [2:0] REG_SPEED_LOW   = 3'd4;
  localparam logic [2:0] REG_SPEED_HIGH  = 3'd5;
  localparam logic [2:0] REG_TANGENTIAL  = 3'd6;

  // Sine polynomial coefficients, Q30
  localparam logic [31:0] SIN_A1 = 32'd1686629713;
  localparam logic [31:0] SIN_A3 = 32'd693598668;
  localparam logic [31:0] SIN_A5 = 32'd85569306;
  localparam logic [31:0] SIN_A7 = 32'd5026995;
  localparam logic [31:0] SIN_A9 = 32'd172272;

  localparam int SqrtSteps = 16;  // result bits of a 32-bit radicand

  // One square-root digit step carried cell to cell
  typedef struct packed {
    logic [31:0] rem;
    logic [16:0] root;
  } sqrt_state_t;

  // Work carried along the datapath chain
  typedef struct packed {
    logic signed [16:0] u;
    logic [15:0]        az;
    logic [16:0]        speed;
    logic [16:0]        radius;
    logic               tang;
  } item_t;

  // Saturate to +-65535
  function automatic logic signed [16:0] sat_out(input logic signed [47:0] v);
    if (v > 48'sd65535) return 17'sd65535;
    else if (v < -48'sd65535) return -17'sd65535;
    else return v[16:0];
  endfunction

  // Round half up from Q15
  function automatic logic signed [47:0] rnd15(input logic signed [47:0] v);
    logic signed [47:0] t;
    t = v + 48'sd16384;
    return t >>> 15;
  endfunction

endpackage

>>> sv/cps_sqrt_cell.sv
// One restoring square-root step: one result bit per cell per cycle while en is high.
module cps_sqrt_cell #(
  parameter int Step = 0
) (
  input  logic                clk,
  input  logic                en,
  input  cps_pkg::sqrt_state_t in_s,
  output cps_pkg::sqrt_state_t out_s
);
  import cps_pkg::*;

  localparam int Shift = 2 * (SqrtSteps - 1 - Step);

  logic [33:0] trial;
  logic [33:0] rem_w;
  sqrt_state_t nxt;

  // trial = (root*4 + 1) << shift compared with remainder
  always_comb begin
    trial = ({15'd0, in_s.root, 2'b01}) << Shift;
    rem_w = {2'b00, in_s.rem};
    nxt   = in_s;
    if (rem_w >= trial) begin
      nxt.rem  = 32'(rem_w - trial);
      nxt.root = {in_s.root[15:0], 1'b1};
    end else begin
      nxt.root = {in_s.root[15:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_s <= nxt;
    end
  end
endmodule

>>> sv/cps_sqrt_chain.sv
// Chain of square-root cells with a side payload that travels alongside.
module cps_sqrt_chain #(
  parameter int PayW = 8
) (
  input  logic            clk,
  input  logic            en,
  input  logic [31:0]     radicand,
  input  logic [PayW-1:0] pay_in,
  output logic [16:0]     root,
  output logic [PayW-1:0] pay_out
);
  import cps_pkg::*;

  sqrt_state_t     st  [SqrtSteps+1];
  logic [PayW-1:0] pay [SqrtSteps+1];

  assign st[0].rem  = radicand;
  assign st[0].root = '0;
  assign pay[0]     = pay_in;

  for (genvar i = 0; i < SqrtSteps; i++) begin : g_cell
    cps_sqrt_cell #(.Step(i)) u_cell (
      .clk(clk), .en(en), .in_s(st[i]), .out_s(st[i+1])
    );
    always_ff @(posedge clk) begin
      if (en) begin
        pay[i+1] <= pay[i];
      end
    end
  end

  assign root    = st[SqrtSteps].root;
  assign pay_out = pay[SqrtSteps];
endmodule

>>> sv/cps_div_cell.sv
// One restoring division step for the tangent normalization.
module cps_div_cell (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] num_in,
  input  logic [16:0] quo_in,
  input  logic [16:0] den,
  input  logic        bit_in,
  output logic [31:0] num_out,
  output logic [16:0] quo_out
);
  logic [32:0] r;

  // shift in one numerator bit, subtract divisor if it fits
  always_comb begin
    r = {num_in, bit_in};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (r >= {16'd0, den}) begin
        num_out <= 32'(r - {16'd0, den});
        quo_out <= {quo_in[15:0], 1'b1};
      end else begin
        num_out <= r[31:0];
        quo_out <= {quo_in[15:0], 1'b0};
      end
    end
  end
endmodule

>>> sv/cone_point_sampler.sv
// Cone point sampler top level: interpolation, sine, sqrt and divider chains.
// Throughput: one word per cycle; the whole pipeline advances when the output is free.
// The pipeline depth is set by the chains of one-bit square-root and division cells.
// Reset (synchronous, rst high) clears valid bits and loads register defaults.
// No clearing pass; ready comes up in the cycle after reset.
module cone_point_sampler (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [63:0]  s_axis_tdata,   // rand_height, rand_azimuth, rand_speed, rand_radius
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [103:0] m_axis_tdata,   // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, 2'b0
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [15:0]  cfg_data
);
  import cps_pkg::*;

  localparam int Lat = 57;

  // configuration registers
  logic signed [15:0] u_low, u_high;
  logic [15:0] radius_low, radius_high, speed_low, speed_high;
  logic        tangential;

  assign cfg_ready = !rst;
  always_ff @(posedge clk) begin
    if (rst) begin
      u_low <= 16'sd32767; u_high <= 16'sd32767;
      radius_low <= '0; radius_high <= '0;
      speed_low <= '0; speed_high <= '0;
      tangential <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_U_LOW:       u_low <= cfg_data;
        REG_U_HIGH:      u_high <= cfg_data;
        REG_RADIUS_LOW:  radius_low <= cfg_data;
        REG_RADIUS_HIGH: radius_high <= cfg_data;
        REG_SPEED_LOW:   speed_low <= cfg_data;
        REG_SPEED_HIGH:  speed_high <= cfg_data;
        REG_TANGENTIAL:  tangential <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // pipeline advances when output register is empty or being taken
  logic en;
  logic [Lat-1:0] vld;
  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en && !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[Lat-2:0], s_axis_tvalid};
    end
  end

  // stage 1: interpolation products
  logic [15:0] rh, ra, rs, rr;
  assign rh = s_axis_tdata[15:0];
  assign ra = s_axis_tdata[31:16];
  assign rs = s_axis_tdata[47:32];
  assign rr = s_axis_tdata[63:48];

  logic signed [16:0] du, dr, dsp;
  assign du  = 17'(u_high) - 17'(u_low);
  assign dr  = $signed({1'b0, radius_high}) - $signed({1'b0, radius_low});
  assign dsp = $signed({1'b0, speed_high}) - $signed({1'b0, speed_low});

  logic signed [33:0] pu, pr, ps;
  logic signed [15:0] l_u; logic [15:0] l_r, l_s, az1; logic t1;
  always_ff @(posedge clk) begin
    if (en) begin
      pu <= $signed({1'b0, rh}) * du;
      pr <= $signed({1'b0, rr}) * dr;
      ps <= $signed({1'b0, rs}) * dsp;
      l_u <= u_low; l_r <= radius_low; l_s <= speed_low;
      az1 <= ra; t1 <= tangential;
    end
  end

  // stage 2: finish interpolation, floor shift
  item_t it2;
  always_ff @(posedge clk) begin
    if (en) begin
      it2.u      <= 17'(l_u) + 17'(pu >>> 16);
      it2.radius <= 17'($signed({1'b0, l_r}) + 17'(pr >>> 16));
      it2.speed  <= 17'($signed({1'b0, l_s}) + 17'(ps >>> 16));
      it2.az     <= az1;
      it2.tang   <= t1;
    end
  end

  // stage 3: u squared
  logic [31:0] usq; item_t it3;
  always_ff @(posedge clk) begin
    if (en) begin
      usq <= 32'(it2.u * it2.u);
      it3 <= it2;
    end
  end

  // stages 4..19: mu = isqrt(2^30 - u^2)
  localparam int ItW = $bits(item_t);
  logic [16:0] mu; item_t it19;
  logic [31:0] rad_mu;
  assign rad_mu = 32'h4000_0000 - usq;
  cps_sqrt_chain #(.PayW(ItW)) u_mu (
    .clk(clk), .en(en), .radicand(rad_mu), .pay_in(it3), .root(mu), .pay_out(it19)
  );

  // sine: polynomial over Horner stages on both w and 16384-w, done in parallel
  // with the sqrt chain (16 stages available, 7 used, rest delay)
  logic [14:0] wa, wb;
  assign wa = {1'b0, it3.az[13:0]};
  assign wb = 15'd16384 - wa;

  logic [14:0] wq [2];
  logic [63:0] pm [2];
  logic [15:0] sv [2];
  // chain of poly stages: s0 z/z2, s1..s4 Horner, s5 final product, s6 round
  logic [31:0] hs [2][5];
  logic [31:0] zs [2][5];
  logic [31:0] z2s [2][5];

  for (genvar k = 0; k < 2; k++) begin : g_sin
    assign wq[k] = (k == 0) ? wa : wb;
    always_ff @(posedge clk) begin
      if (en) begin
        zs[k][0]  <= {wq[k][14:0], 16'd0, 1'b0} >> 1;
        z2s[k][0] <= 32'((64'({1'b0, wq[k], 16'd0}) * 64'({1'b0, wq[k], 16'd0})) >> 30);
        hs[k][0]  <= SIN_A9;
      end
    end
    for (genvar j = 0; j < 4; j++) begin : g_h
      logic [31:0] c;
      assign c = (j == 0) ? SIN_A7 : (j == 1) ? SIN_A5 : (j == 2) ? SIN_A3 : SIN_A1;
      always_ff @(posedge clk) begin
        if (en) begin
          hs[k][j+1]  <= c - 32'((64'(z2s[k][j]) * 64'(hs[k][j])) >> 30);
          z2s[k][j+1] <= z2s[k][j];
          zs[k][j+1]  <= zs[k][j];
        end
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        pm[k] <= (64'(zs[k][4]) * 64'(hs[k][4])) >> 30;
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        sv[k] <= (((pm[k] + 64'd16384) >> 15) > 64'd32768) ? 16'd32768
               : 16'((pm[k] + 64'd16384) >> 15);
      end
    end
  end

  // delay sine results to line up with mu (7 stages used, 9 more)
  logic [15:0] sa_d [10], sb_d [10];
  assign sa_d[0] = sv[0];
  assign sb_d[0] = sv[1];
  for (genvar d = 0; d < 9; d++) begin : g_sd
    always_ff @(posedge clk) begin
      if (en) begin
        sa_d[d+1] <= sa_d[d];
        sb_d[d+1] <= sb_d[d];
      end
    end
  end

  // stage 20: sign by quadrant, unit x and z products
  logic signed [17:0] sn, cs;
  always_comb begin
    case (it19.az[15:14])
      2'd0: begin sn = 18'(sa_d[9]);  cs = 18'(sb_d[9]);  end
      2'd1: begin sn = 18'(sb_d[9]);  cs = -18'(sa_d[9]); end
      2'd2: begin sn = -18'(sa_d[9]); cs = -18'(sb_d[9]); end
      default: begin sn = -18'(sb_d[9]); cs = 18'(sa_d[9]); end
    endcase
  end

  logic signed [35:0] mxc, mzs; item_t it20;
  always_ff @(posedge clk) begin
    if (en) begin
      mxc  <= $signed({1'b0, mu}) * cs;
      mzs  <= $signed({1'b0, mu}) * sn;
      it20 <= it19;
    end
  end

  // stage 21: unit vector
  logic signed [17:0] ux, uz; item_t it21;
  always_ff @(posedge clk) begin
    if (en) begin
      ux <= 18'(rnd15(48'(mxc)));
      uz <= 18'(rnd15(48'(mzs)));
      it21 <= it20;
    end
  end

  // stage 22: squares and radius products
  logic [31:0] ssum; item_t it22; logic signed [17:0] ux22, uz22;
  logic signed [47:0] prx, pry, prz;
  always_ff @(posedge clk) begin
    if (en) begin
      ssum <= 32'(ux * ux) + 32'(uz * uz);
      prx  <= 48'($signed({1'b0, it21.radius}) * ux);
      pry  <= 48'($signed({1'b0, it21.radius}) * it21.u);
      prz  <= 48'($signed({1'b0, it21.radius}) * uz);
      ux22 <= ux; uz22 <= uz; it22 <= it21;
    end
  end

  // stages 23..38: L = isqrt(x^2+z^2), carrying vector and positions
  localparam int PW = ItW + 36 + 51;
  logic [PW-1:0] p22, p38;
  logic [16:0] len;
  logic signed [16:0] px22, py22, pz22;
  assign px22 = sat_out(rnd15(prx));
  assign py22 = sat_out(rnd15(pry));
  assign pz22 = sat_out(rnd15(prz));
  assign p22 = {it22, ux22, uz22, px22, py22, pz22};
  cps_sqrt_chain #(.PayW(PW)) u_len (
    .clk(clk), .en(en), .radicand(ssum), .pay_in(p22), .root(len), .pay_out(p38)
  );

  item_t it38; logic signed [17:0] ux38, uz38; logic [50:0] pos38;
  assign {it38, ux38, uz38, pos38} = p38;

  // stages 39..55: two dividers, |c|*2^15 + L/2 over L, 17 quotient bits
  logic [31:0] na, nb;
  assign na = 32'({uz38[17] ? 18'(-uz38) : uz38, 15'd0}) + 32'(len >> 1);
  assign nb = 32'({ux38[17] ? 18'(-ux38) : ux38, 15'd0}) + 32'(len >> 1);
  localparam int DS = 17;
  localparam int DW = ItW + 36 + 51 + 17;
  logic [31:0] ra_n [DS+1], rb_n [DS+1], ra_r [DS+1], rb_r [DS+1];
  logic [16:0] qa [DS+1], qb [DS+1];
  logic [DW-1:0] dp [DS+1];
  assign ra_n[0] = {na[16:0], 15'd0}; assign rb_n[0] = {nb[16:0], 15'd0};
  assign ra_r[0] = {17'd0, na[31:17]}; assign rb_r[0] = {17'd0, nb[31:17]};
  assign qa[0] = '0; assign qb[0] = '0;
  assign dp[0] = {p38, len};
  for (genvar i = 0; i < DS; i++) begin : g_div
    cps_div_cell u_da (.clk(clk), .en(en), .num_in(ra_r[i]), .quo_in(qa[i]),
      .den(dp[i][16:0]), .bit_in(ra_n[i][31]), .num_out(ra_r[i+1]), .quo_out(qa[i+1]));
    cps_div_cell u_db (.clk(clk), .en(en), .num_in(rb_r[i]), .quo_in(qb[i]),
      .den(dp[i][16:0]), .bit_in(rb_n[i][31]), .num_out(rb_r[i+1]), .quo_out(qb[i+1]));
    always_ff @(posedge clk) begin
      if (en) begin
        ra_n[i+1] <= {ra_n[i][30:0], 1'b0};
        rb_n[i+1] <= {rb_n[i][30:0], 1'b0};
        dp[i+1]   <= dp[i];
      end
    end
  end

  // Quotient fits 17 bits only for the low 17 numerator bits; numerator is
  // at most 2^32, so bring in the top 15 bits first via the initial remainder.
  item_t it55; logic signed [17:0] ux55, uz55; logic [50:0] pos55; logic [16:0] len55;
  assign {it55, ux55, uz55, pos55, len55} = dp[DS];

  logic [16:0] mqa, mqb;
  assign mqa = (qa[DS] > 17'd32768) ? 17'd32768 : qa[DS];
  assign mqb = (qb[DS] > 17'd32768) ? 17'd32768 : qb[DS];

  // stage 56: velocity vector select
  logic signed [17:0] vx, vy, vz; item_t it56; logic [50:0] pos56;
  always_ff @(posedge clk) begin
    if (en) begin
      it56 <= it55; pos56 <= pos55;
      if (!it55.tang) begin
        vx <= ux55; vy <= 18'(it55.u); vz <= uz55;
      end else if (len55 == 17'd0) begin
        vx <= '0; vy <= '0; vz <= '0;
      end else begin
        vx <= uz55[17] ? -18'(mqa) : 18'(mqa);
        vy <= '0;
        vz <= ux55[17] ? 18'(mqb) : -18'(mqb);
      end
    end
  end

  // stage 57: speed products
  logic signed [47:0] vpx, vpy, vpz; logic [50:0] pos57;
  always_ff @(posedge clk) begin
    if (en) begin
      vpx <= 48'($signed({1'b0, it56.speed}) * vx);
      vpy <= 48'($signed({1'b0, it56.speed}) * vy);
      vpz <= 48'($signed({1'b0, it56.speed}) * vz);
      pos57 <= pos56;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      m_axis_tvalid <= vld[Lat-1];
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      m_axis_tdata <= {2'b00, sat_out(rnd15(vpz)), sat_out(rnd15(vpy)),
                       sat_out(rnd15(vpx)), pos57[16:0], pos57[33:17], pos57[50:34]};
    end
  end

  // output held while stalled
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output changed under stall");
  // a stalled full pipe must refuse input
  a_stall: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready && vld[Lat-1] |-> !s_axis_tready)
    else $error("input taken while full pipe stalled");
  // output valid only follows a word reaching the last stage
  a_src: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(vld[Lat-1]))
    else $error("output valid without source");
endmodule

>>> dv/cone_point_sampler_test.sv
// Self-checking testbench for the cone point sampler.
module cone_point_sampler_test;
  import cps_pkg::*;

  localparam int LATENCY   = 57;
  localparam int WDOG_MAX  = 20000;
  localparam int N_RANDOM  = 1700;

  typedef struct packed {
    logic signed [16:0] vz, vy, vx, pz, py, px;
  } particle_t;

  typedef struct {
    logic [15:0] rh, ra, rs, rr;
    logic        has_exp;
    particle_t   exp_p;
  } stim_row_t;

  logic clk = 1'b0, rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [103:0] m_axis_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  cone_point_sampler i_dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Predictor copy of the registers
  logic signed [16:0] cur_u_low, cur_u_high;
  logic [15:0] cur_r_low, cur_r_high, cur_s_low, cur_s_high;
  logic cur_tang;

  particle_t expected_particles[$];
  int  mismatches = 0;
  int  words_out = 0;
  int  idle_cycles = 0;
  bit  hold_off = 1'b0;

  function automatic longint floor_div_pow2(longint v, int s);
    return v >>> s;  // arithmetic shift is floor
  endfunction

  function automatic longint round_q15_ll(longint v);
    return (v + 16384) >>> 15;
  endfunction

  function automatic longint int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Quarter-wave sine, Q15, odd Taylor polynomial with truncating steps
  function automatic longint quarter_sine(longint unsigned w);
    longint unsigned z, z2, h, s;
    z  = w << 16;
    z2 = (z * z) >> 30;
    h  = 172272;
    h  = 5026995    - ((z2 * h) >> 30);
    h  = 85569306   - ((z2 * h) >> 30);
    h  = 693598668  - ((z2 * h) >> 30);
    h  = 1686629713 - ((z2 * h) >> 30);
    s  = (z * h) >> 30;
    s  = (s + 16384) >> 15;
    if (s > 32768) s = 32768;
    return s;
  endfunction

  function automatic longint interp(longint lo, longint hi, longint frac);
    return lo + floor_div_pow2(frac * (hi - lo), 16);
  endfunction

  function automatic logic signed [16:0] clamp_out(longint v);
    if (v > 65535) v = 65535;
    if (v < -65535) v = -65535;
    return v[16:0];
  endfunction

  function automatic longint norm_tangent(longint c, longint len);
    longint m, n;
    m = c < 0 ? -c : c;
    n = ((m << 15) + (len >> 1)) / len;
    if (n > 32768) n = 32768;
    return c < 0 ? -n : n;
  endfunction

  function automatic particle_t emit_particle(logic [15:0] rh, logic [15:0] ra,
                                              logic [15:0] rs, logic [15:0] rr);
    particle_t p;
    longint u, mu, sa, sb, sn, cs, ux, uz, spd, rad, vx, vy, vz, len;
    u  = interp(cur_u_low, cur_u_high, rh);
    mu = int_sqrt(64'd1073741824 - u * u);
    sa = quarter_sine(ra[13:0]);
    sb = quarter_sine(16384 - ra[13:0]);
    case (ra[15:14])
      2'd0: begin sn = sa;  cs = sb;  end
      2'd1: begin sn = sb;  cs = -sa; end
      2'd2: begin sn = -sa; cs = -sb; end
      default: begin sn = -sb; cs = sa; end
    endcase
    ux  = round_q15_ll(mu * cs);
    uz  = round_q15_ll(mu * sn);
    spd = interp(cur_s_low, cur_s_high, rs);
    rad = interp(cur_r_low, cur_r_high, rr);
    p.px = clamp_out(round_q15_ll(rad * ux));
    p.py = clamp_out(round_q15_ll(rad * u));
    p.pz = clamp_out(round_q15_ll(rad * uz));
    vx = ux; vy = u; vz = uz;
    if (cur_tang) begin
      len = int_sqrt(uz * uz + ux * ux);
      if (len == 0) begin
        vx = 0; vy = 0; vz = 0;
      end else begin
        vx = norm_tangent(uz, len);
        vy = 0;
        vz = norm_tangent(-ux, len);
      end
    end
    p.vx = clamp_out(round_q15_ll(spd * vx));
    p.vy = clamp_out(round_q15_ll(spd * vy));
    p.vz = clamp_out(round_q15_ll(spd * vz));
    return p;
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_U_LOW:       cur_u_low  = $signed(val);
      REG_U_HIGH:      cur_u_high = $signed(val);
      REG_RADIUS_LOW:  cur_r_low  = val;
      REG_RADIUS_HIGH: cur_r_high = val;
      REG_SPEED_LOW:   cur_s_low  = val;
      REG_SPEED_HIGH:  cur_s_high = val;
      REG_TANGENTIAL:  cur_tang   = val[0];
      default: ;
    endcase
  endtask

  task automatic set_regs(logic [15:0] ul, logic [15:0] uh, logic [15:0] rl,
                          logic [15:0] rh, logic [15:0] sl, logic [15:0] sh, bit tg);
    write_reg(REG_U_LOW, ul);
    write_reg(REG_U_HIGH, uh);
    write_reg(REG_RADIUS_LOW, rl);
    write_reg(REG_RADIUS_HIGH, rh);
    write_reg(REG_SPEED_LOW, sl);
    write_reg(REG_SPEED_HIGH, sh);
    write_reg(REG_TANGENTIAL, {15'd0, tg});
  endtask

  // Send one word, queue its expected particle; valid stays high back to back when the random gap is zero
  task automatic send_word(logic [15:0] rh, logic [15:0] ra, logic [15:0] rs,
                           logic [15:0] rr, bit has_exp, particle_t typed_exp);
    int g;
    g = gap_len();
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {rr, rs, ra, rh};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    expected_particles.push_back(has_exp ? typed_exp : emit_particle(rh, ra, rs, rr));
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (expected_particles.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // Output check
  always @(posedge clk) begin
    particle_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[101:0];
      words_out++;
      if (expected_particles.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected output word %h", got);
      end else begin
        want = expected_particles.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("word %0d: expected px %0d py %0d pz %0d vx %0d vy %0d vz %0d, got px %0d py %0d pz %0d vx %0d vy %0d vz %0d",
                     words_out, want.px, want.py, want.pz, want.vx, want.vy, want.vz,
                     got.px, got.py, got.pz, got.vx, got.vy, got.vz);
        end
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off
  initial begin
    int g;
    @(negedge rst);
    forever begin
      if (hold_off) begin
        m_axis_tready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
      end
      g = gap_len();
      if (g > 0 && $urandom_range(0, 3) != 0) begin
        m_axis_tready <= 1'b0;
        repeat (g) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk);
    end
  end

  // Watchdog on cycles with no accepted word or register write
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WDOG_MAX) begin
        $display("watchdog expired, %0d words pending", expected_particles.size());
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin
    stim_row_t directed[$];
    particle_t zero_p;
    zero_p = '0;
    cur_u_low = 32767; cur_u_high = 32767;
    cur_r_low = 0; cur_r_high = 0; cur_s_low = 0; cur_s_high = 0; cur_tang = 0;

    // Reset values: radius and speed zero, so every field is zero
    directed.push_back('{16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, zero_p});
    directed.push_back('{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, zero_p});

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i])
      send_word(directed[i].rh, directed[i].ra, directed[i].rs, directed[i].rr,
                directed[i].has_exp, directed[i].exp_p);
    drain();

    // Full hemisphere-and-beyond, max radius and speed: saturation
    set_regs(16'h8000, 16'h7FFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
    for (int q = 0; q < 4; q++) begin
      send_word(16'h0000, 16'(q << 14), 16'hFFFF, 16'h0000, 1'b0, zero_p);
      send_word(16'hFFFF, 16'((q << 14) | 16'h3FFF), 16'h0000, 16'hFFFF, 1'b0, zero_p);
      send_word(16'h8000, 16'((q << 14) | 16'h2000), 16'h8000, 16'h8000, 1'b0, zero_p);
    end
    drain();
    // Reversed bounds and tangential mode; pole gives zero tangent
    set_regs(16'h7FFF, 16'h8000, 16'h4000, 16'h0100, 16'h2000, 16'h0080, 1'b1);
    send_word(16'h0000, 16'h1234, 16'h0000, 16'hFFFF, 1'b0, zero_p);
    send_word(16'hFFFF, 16'h9ABC, 16'hFFFF, 16'h0000, 1'b0, zero_p);
    send_word(16'h8000, 16'h4000, 16'h7FFF, 16'h8001, 1'b0, zero_p);
    send_word(16'h4000, 16'hC000, 16'h1111, 16'h2222, 1'b0, zero_p);
    drain();
    // Exact pole (u fixed at -1): tangent vanishes
    set_regs(16'h8000, 16'h8000, 16'h0200, 16'h0200, 16'h0300, 16'h0300, 1'b1);
    send_word(16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0, 1'b0, zero_p);
    send_word(16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF, 1'b0, zero_p);
    drain();

    // Random phases with random settings; one phase stalls the output hard
    for (int ph = 0; ph < 8; ph++) begin
      set_regs(16'($urandom), 16'($urandom), 16'($urandom_range(0, 65535) >> $urandom_range(0, 8)),
               16'($urandom_range(0, 65535) >> $urandom_range(0, 8)),
               16'($urandom_range(0, 65535) >> $urandom_range(0, 8)),
               16'($urandom_range(0, 65535) >> $urandom_range(0, 8)), ph[0]);
      if (ph == 3) hold_off = 1'b1;
      repeat (N_RANDOM / 8)
        send_word(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 1'b0, zero_p);
      drain();
    end
    // Back to the reset settings explicitly
    set_regs(16'h7FFF, 16'h7FFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
    send_word(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 1'b0, zero_p);
    drain();

    $display("covered %0d output words over directed extremes, reversed bounds,", words_out);
    $display("zero tangent, saturation and eight random register settings");
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

>>> files.f
sv/cps_pkg.sv
sv/cps_sqrt_cell.sv
sv/cps_sqrt_chain.sv
sv/cps_div_cell.sv
sv/cone_point_sampler.sv
dv/cone_point_sampler_test.sv
